// ----- design/csr_pkg.sv -----
// Shared constants, request types and status types for the circle span rasterizer.
// Used by every module of the block; depends on nothing.
package csr_pkg;

    localparam int MAX_RADIUS_DEF = 15;
    localparam int RAD_W          = 4;
    localparam int COORD_W        = 12;
    localparam int X_W            = COORD_W + 1;
    localparam int ROW_W          = 10;
    localparam int COL_W          = 11;
    localparam int SQ_W           = 2 * RAD_W;
    localparam int RT_W           = RAD_W;
    localparam int BIT_W          = $clog2(RT_W);
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 11;

    localparam logic [COL_W-1:0] FW_RESET = 11'd1024;
    localparam logic [ROW_W-1:0] FH_RESET = 10'd480;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic                      mode;
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic [RAD_W-1:0]          radius;
        logic [RAD_W-1:0]          thickness;
    } circle_req_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] span_start;
        logic [COL_W-1:0] span_end;
        logic             last;
    } span_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } sq_stat_t;

endpackage

// ----- design/csr_stream_if.sv -----
// Valid/ready stream interface carrying one request of a chosen payload type.
// The payload types come from csr_pkg.
interface csr_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- design/csr_isqrt.sv -----
// Iterative floor square root, one result bit per cycle by trial squaring.
// Depends on csr_pkg for widths and the status type.
module csr_isqrt (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [csr_pkg::SQ_W-1:0]  operand,
    output csr_pkg::sq_stat_t         stat,
    output logic [csr_pkg::RT_W-1:0]  root
);

    logic [csr_pkg::SQ_W-1:0]  val_reg;
    logic [csr_pkg::RT_W-1:0]  root_reg;
    logic [csr_pkg::RT_W-1:0]  root_next;
    logic [csr_pkg::BIT_W-1:0] bit_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic [csr_pkg::RT_W-1:0]  trial;
    logic [csr_pkg::SQ_W-1:0]  trial_sq;

    always_comb
    begin
        trial     = root_reg | (csr_pkg::RT_W'(1) << bit_reg);
        trial_sq  = csr_pkg::SQ_W'(trial) * csr_pkg::SQ_W'(trial);
        root_next = (trial_sq <= val_reg) ? trial : root_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg  <= '0;
            root_reg <= '0;
            bit_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            val_reg  <= operand;
            root_reg <= '0;
            bit_reg  <= csr_pkg::BIT_W'(csr_pkg::RT_W - 1);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            root_reg <= root_next;
            if (bit_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                bit_reg <= bit_reg - 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign root      = root_reg;

endmodule

// ----- design/csr_span_clip.sv -----
// Clamps a signed column interval to the visible frame and flags empty spans.
// Depends on csr_pkg for widths.
module csr_span_clip (
    input  logic signed [csr_pkg::X_W-1:0] x_lo,
    input  logic signed [csr_pkg::X_W-1:0] x_hi,
    input  logic [csr_pkg::COL_W-1:0]      width,
    output logic                           ok,
    output logic [csr_pkg::COL_W-1:0]      lo,
    output logic [csr_pkg::COL_W-1:0]      hi
);

    logic signed [csr_pkg::X_W-1:0] wm1;
    logic signed [csr_pkg::X_W-1:0] lo_c;
    logic signed [csr_pkg::X_W-1:0] hi_c;

    always_comb
    begin
        wm1  = $signed({2'b00, width}) - $signed(csr_pkg::X_W'(1));
        lo_c = (x_lo < 0) ? '0 : x_lo;
        hi_c = (x_hi > wm1) ? wm1 : x_hi;
        ok   = (lo_c <= hi_c);
        lo   = lo_c[csr_pkg::COL_W-1:0];
        hi   = hi_c[csr_pkg::COL_W-1:0];
    end

endmodule

// ----- design/circle_span_rasterizer.sv -----
// Top level of the circle span rasterizer: sequencer, frame registers, output stage.
// Depends on csr_pkg, csr_stream_if, csr_isqrt and csr_span_clip.
//
// A circle request enters on the circle channel and the block answers with
// horizontal spans on the span channel, top row first; the last span of a
// circle carries last. A circle that covers no visible pixel yields no span.
// The frame size is set through the write port (index 0 width, index 1
// height); the user must write it only while the block is idle, and the
// block itself does not enforce this. The block takes one circle at a time.
// A circle passes through setup, then for each visible row through the
// square root of the outer half-width, for a ring row with an inner
// half-width also of the inner one, and the span states, then a flush; the
// shared 4-step square root unit serves the outer and the inner half-width.
// Spans are held one deep so the last one can be marked, then go to an
// output register; a stalled receiver holds the sequencer at its next span
// and a new circle is accepted while the final span still waits.
// Reset restores width 1024 and height 480 and empties the output stage.
module circle_span_rasterizer #(
    parameter int MAX_RADIUS = csr_pkg::MAX_RADIUS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    csr_stream_if.sink                      circle,
    csr_stream_if.source                    span,
    input  logic                            cfg_we,
    input  logic [csr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [csr_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int RW = csr_pkg::RAD_W;
    localparam int XW = csr_pkg::X_W;
    localparam int SW = csr_pkg::SQ_W;
    localparam int YW = csr_pkg::ROW_W;
    localparam logic [RW-1:0] R_MAX = RW'(MAX_RADIUS);

    typedef enum logic [3:0] {
        S_IDLE, S_SETUP, S_ROW, S_SQO, S_WO, S_SQI, S_WI, S_SPL, S_SPR, S_FLUSH
    } state_t;

    state_t state_reg, state_next;

    logic [csr_pkg::COL_W-1:0] frame_width_reg;
    logic [YW-1:0]             frame_height_reg;

    logic                              ring_reg, ring_next;
    logic signed [csr_pkg::COORD_W-1:0] cx_reg, cx_next;
    logic signed [csr_pkg::COORD_W-1:0] cy_reg, cy_next;
    logic [RW-1:0]                     r_reg, r_next;
    logic [RW-1:0]                     inner_reg, inner_next;
    logic [SW-1:0]                     r2_reg, r2_next;
    logic [SW-1:0]                     in2_reg, in2_next;
    logic [SW-1:0]                     dy2_reg, dy2_next;
    logic [YW-1:0]                     y_reg, y_next;
    logic [YW-1:0]                     y1_reg, y1_next;
    logic [RW-1:0]                     dout_reg, dout_next;
    logic [RW-1:0]                     din_reg, din_next;
    logic                              pend_valid_reg, pend_valid_next;
    csr_pkg::span_req_t                pend_reg, pend_next;
    logic                              out_valid_reg, out_valid_next;
    csr_pkg::span_req_t                out_reg, out_next;

    logic                  sq_start;
    logic [SW-1:0]         sq_operand;
    csr_pkg::sq_stat_t     sq_stat;
    logic [RW-1:0]         sq_root;

    logic signed [XW-1:0]  clip_lo_in;
    logic signed [XW-1:0]  clip_hi_in;
    logic                  clip_ok;
    logic [csr_pkg::COL_W-1:0] clip_lo;
    logic [csr_pkg::COL_W-1:0] clip_hi;

    logic [RW-1:0]         rsat;
    logic signed [XW-1:0]  cx_ext;
    logic signed [XW-1:0]  cy_ext;
    logic signed [XW-1:0]  ylo;
    logic signed [XW-1:0]  yhi;
    logic signed [XW-1:0]  fhm1;
    logic signed [XW-1:0]  dy;
    logic signed [XW-1:0]  dy_abs;
    logic signed [XW-1:0]  dout_ext;
    logic signed [XW-1:0]  din_ext;
    logic                  out_free;
    logic                  span_go;
    logic                  row_done;

    csr_isqrt u_isqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sq_start),
        .operand (sq_operand),
        .stat    (sq_stat),
        .root    (sq_root)
    );

    csr_span_clip u_clip (
        .x_lo  (clip_lo_in),
        .x_hi  (clip_hi_in),
        .width (frame_width_reg),
        .ok    (clip_ok),
        .lo    (clip_lo),
        .hi    (clip_hi)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= csr_pkg::FW_RESET;
            frame_height_reg <= csr_pkg::FH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                csr_pkg::CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[csr_pkg::COL_W-1:0];
                csr_pkg::CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data[YW-1:0];
            endcase
        end
    end

    always_comb
    begin
        rsat     = (circle.payload.radius > R_MAX) ? R_MAX : circle.payload.radius;
        cx_ext   = $signed({cx_reg[csr_pkg::COORD_W-1], cx_reg});
        cy_ext   = $signed({cy_reg[csr_pkg::COORD_W-1], cy_reg});
        ylo      = cy_ext - $signed({{(XW-RW){1'b0}}, r_reg});
        yhi      = cy_ext + $signed({{(XW-RW){1'b0}}, r_reg});
        fhm1     = $signed({{(XW-YW){1'b0}}, frame_height_reg}) - $signed(XW'(1));
        if (ylo < 0)
            ylo = '0;
        if (yhi > fhm1)
            yhi = fhm1;
        dy       = $signed({{(XW-YW){1'b0}}, y_reg}) - cy_ext;
        dy_abs   = dy[XW-1] ? -dy : dy;
        dout_ext = $signed({{(XW-RW){1'b0}}, dout_reg});
        din_ext  = $signed({{(XW-RW){1'b0}}, din_reg});
        out_free = !out_valid_reg || span.ready;

        if (state_reg == S_SPR)
        begin
            clip_lo_in = cx_ext + din_ext;
            clip_hi_in = cx_ext + dout_ext;
        end
        else
        begin
            clip_lo_in = cx_ext - dout_ext;
            clip_hi_in = ring_reg ? (cx_ext - din_ext) : (cx_ext + dout_ext);
        end
        span_go  = !clip_ok || !pend_valid_reg || out_free;
        row_done = (y_reg == y1_reg);

        state_next      = state_reg;
        ring_next       = ring_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        r_next          = r_reg;
        inner_next      = inner_reg;
        r2_next         = r2_reg;
        in2_next        = in2_reg;
        dy2_next        = dy2_reg;
        y_next          = y_reg;
        y1_next         = y1_reg;
        dout_next       = dout_reg;
        din_next        = din_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !span.ready;
        out_next        = out_reg;
        sq_start        = 1'b0;
        sq_operand      = r2_reg - dy2_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (circle.valid)
                begin
                    ring_next  = circle.payload.mode;
                    cx_next    = circle.payload.center_x;
                    cy_next    = circle.payload.center_y;
                    r_next     = rsat;
                    inner_next = (rsat > circle.payload.thickness) ?
                                 (rsat - circle.payload.thickness) : '0;
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                r2_next  = SW'(r_reg) * SW'(r_reg);
                in2_next = SW'(inner_reg) * SW'(inner_reg);
                y_next   = ylo[YW-1:0];
                y1_next  = yhi[YW-1:0];
                state_next = (ylo > yhi) ? S_FLUSH : S_ROW;
            end
            S_ROW:
            begin
                dy2_next   = SW'(dy_abs[RW-1:0]) * SW'(dy_abs[RW-1:0]);
                state_next = S_SQO;
            end
            S_SQO:
            begin
                sq_start   = 1'b1;
                state_next = S_WO;
            end
            S_WO:
            begin
                if (sq_stat.done)
                begin
                    dout_next = sq_root;
                    if (ring_reg && (in2_reg > dy2_reg))
                    begin
                        state_next = S_SQI;
                    end
                    else
                    begin
                        din_next   = '0;
                        state_next = S_SPL;
                    end
                end
            end
            S_SQI:
            begin
                sq_start   = 1'b1;
                sq_operand = in2_reg - dy2_reg;
                state_next = S_WI;
            end
            S_WI:
            begin
                if (sq_stat.done)
                begin
                    din_next   = sq_root;
                    state_next = S_SPL;
                end
            end
            S_SPL, S_SPR:
            begin
                if (span_go)
                begin
                    if (clip_ok)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_next       = pend_reg;
                        end
                        pend_valid_next      = 1'b1;
                        pend_next.row        = y_reg;
                        pend_next.span_start = clip_lo;
                        pend_next.span_end   = clip_hi;
                        pend_next.last       = 1'b0;
                    end
                    if ((state_reg == S_SPL) && ring_reg)
                    begin
                        state_next = S_SPR;
                    end
                    else if (row_done)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        y_next     = y_reg + 1'b1;
                        state_next = S_ROW;
                    end
                end
            end
            S_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_next        = pend_reg;
                    out_next.last   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ring_reg       <= 1'b0;
            cx_reg         <= '0;
            cy_reg         <= '0;
            r_reg          <= '0;
            inner_reg      <= '0;
            r2_reg         <= '0;
            in2_reg        <= '0;
            dy2_reg        <= '0;
            y_reg          <= '0;
            y1_reg         <= '0;
            dout_reg       <= '0;
            din_reg        <= '0;
            pend_valid_reg <= 1'b0;
            pend_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            ring_reg       <= ring_next;
            cx_reg         <= cx_next;
            cy_reg         <= cy_next;
            r_reg          <= r_next;
            inner_reg      <= inner_next;
            r2_reg         <= r2_next;
            in2_reg        <= in2_next;
            dy2_reg        <= dy2_next;
            y_reg          <= y_next;
            y1_reg         <= y1_next;
            dout_reg       <= dout_next;
            din_reg        <= din_next;
            pend_valid_reg <= pend_valid_next;
            pend_reg       <= pend_next;
            out_valid_reg  <= out_valid_next;
            out_reg        <= out_next;
        end
    end

    assign circle.ready = (state_reg == S_IDLE);
    assign span.valid   = out_valid_reg;
    assign span.payload = out_reg;

    // The root unit is never restarted while it is still iterating.
    a_sq_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        sq_start |-> !sq_stat.busy)
        else $error("square root started while busy");

    // A stalled span request stays offered and unchanged until it is taken.
    a_span_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (span.valid && !span.ready) |=> (span.valid && $stable(span.payload)))
        else $error("stalled span changed or dropped");

    // Clipping never yields an inverted span.
    a_span_order: assert property (@(posedge clk) disable iff (!rst_n)
        span.valid |-> (span.payload.span_start <= span.payload.span_end))
        else $error("span start beyond span end");

    // A new circle is only taken when no span of the previous one is pending.
    a_accept_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (circle.valid && circle.ready) |-> !pend_valid_reg)
        else $error("circle accepted with a pending span");

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for circle_span_rasterizer: directed and random circles in,
// spans checked in order. Depends on csr_pkg and csr_stream_if from the design folder.
module tb_top;

    localparam int QUIET_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 600;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [csr_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [csr_pkg::CFG_DATA_W-1:0] cfg_data;

    csr_stream_if #(.payload_t(csr_pkg::circle_req_t)) circle_if ();
    csr_stream_if #(.payload_t(csr_pkg::span_req_t)) span_if ();

    circle_span_rasterizer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .circle    (circle_if),
        .span      (span_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    logic [csr_pkg::COL_W-1:0] width_copy;
    logic [csr_pkg::ROW_W-1:0] height_copy;
    csr_pkg::circle_req_t circle_queue[$];
    csr_pkg::span_req_t span_expect[$];
    bit offer_open;
    int send_idle_pct;
    int recv_stall_pct;
    int quiet_cycles;
    int circles_sent;
    int spans_checked;
    int errors;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    task automatic report_mismatch(string what, int got, int want);
        $display("ERROR at %0t: %s got %0d expected %0d", $time, what, got, want);
        errors++;
    endtask

    function automatic int root_floor(int v);
        int s;
        s = 0;
        if (v <= 0)
            return 0;
        while ((s + 1) * (s + 1) <= v)
            s++;
        return s;
    endfunction

    function automatic bit clip_span(int y, int x0, int x1, output csr_pkg::span_req_t s);
        int w;
        w = int'(width_copy);
        s = '0;
        if (x0 < 0)
            x0 = 0;
        if (x1 > w - 1)
            x1 = w - 1;
        s.row = csr_pkg::ROW_W'(y);
        s.span_start = csr_pkg::COL_W'(x0);
        s.span_end = csr_pkg::COL_W'(x1);
        return x0 <= x1;
    endfunction

    function automatic void predict_spans(csr_pkg::circle_req_t c);
        csr_pkg::span_req_t found[$];
        csr_pkg::span_req_t s;
        int cx;
        int cy;
        int r;
        int inner;
        int y_top;
        int y_bot;
        int dy2;
        int d_out;
        int d_in;
        cx = $signed(c.center_x);
        cy = $signed(c.center_y);
        r = int'(c.radius);
        if (r > csr_pkg::MAX_RADIUS_DEF)
            r = csr_pkg::MAX_RADIUS_DEF;
        inner = r - int'(c.thickness);
        if (inner < 0)
            inner = 0;
        y_top = (cy - r < 0) ? 0 : cy - r;
        y_bot = (cy + r > int'(height_copy) - 1) ? int'(height_copy) - 1 : cy + r;
        for (int y = y_top; y <= y_bot; y++)
        begin
            dy2 = (y - cy) * (y - cy);
            d_out = root_floor(r * r - dy2);
            if (!c.mode)
            begin
                if (clip_span(y, cx - d_out, cx + d_out, s))
                    found.push_back(s);
            end
            else
            begin
                d_in = (inner * inner > dy2) ? root_floor(inner * inner - dy2) : 0;
                if (clip_span(y, cx - d_out, cx - d_in, s))
                    found.push_back(s);
                if (clip_span(y, cx + d_in, cx + d_out, s))
                    found.push_back(s);
            end
        end
        foreach (found[i])
        begin
            s = found[i];
            s.last = (i == found.size() - 1);
            span_expect.push_back(s);
        end
    endfunction

    function automatic csr_pkg::circle_req_t make_circle(bit mode, int cx, int cy, int r,
                                                         int t);
        csr_pkg::circle_req_t c;
        c.mode = mode;
        c.center_x = csr_pkg::COORD_W'(cx);
        c.center_y = csr_pkg::COORD_W'(cy);
        c.radius = csr_pkg::RAD_W'(r);
        c.thickness = csr_pkg::RAD_W'(t);
        return c;
    endfunction

    function automatic csr_pkg::circle_req_t random_circle();
        int cx;
        int cy;
        if ($urandom_range(9) < 2)
        begin
            cx = $urandom;
            cy = $urandom;
        end
        else
        begin
            cx = int'($urandom_range(int'(width_copy) + 40)) - 20;
            cy = int'($urandom_range(int'(height_copy) + 40)) - 20;
        end
        return make_circle(1'($urandom_range(1)), cx, cy, int'($urandom_range(15)),
                           int'($urandom_range(15)));
    endfunction

    task automatic write_reg(logic [csr_pkg::CFG_IDX_W-1:0] idx, int value);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = csr_pkg::CFG_DATA_W'(value);
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == csr_pkg::CFG_FRAME_WIDTH)
            width_copy = csr_pkg::COL_W'(value);
        else
            height_copy = csr_pkg::ROW_W'(value);
    endtask

    task automatic drain();
        while (circle_queue.size() != 0 || offer_open || span_expect.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(int send_pct, int stall_pct, int count);
        send_idle_pct = send_pct;
        recv_stall_pct = stall_pct;
        repeat (count) circle_queue.push_back(random_circle());
        drain();
    endtask

    always @(negedge clk)
    begin
        if (rst_n && !offer_open)
        begin
            if (circle_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                circle_if.valid <= 1'b1;
                circle_if.payload <= circle_queue[0];
                offer_open = 1'b1;
            end
            else
            begin
                circle_if.valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        span_if.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        csr_pkg::span_req_t want;
        csr_pkg::span_req_t got;
        quiet_cycles++;
        if (rst_n && circle_if.valid && circle_if.ready)
        begin
            predict_spans(circle_queue.pop_front());
            offer_open = 1'b0;
            circles_sent++;
            quiet_cycles = 0;
        end
        if (rst_n && span_if.valid && span_if.ready)
        begin
            quiet_cycles = 0;
            got = span_if.payload;
            if (span_expect.size() == 0)
            begin
                report_mismatch("unexpected span on row", int'(got.row), -1);
            end
            else
            begin
                want = span_expect.pop_front();
                spans_checked++;
                if (got.row != want.row)
                    report_mismatch("row", int'(got.row), int'(want.row));
                if (got.span_start != want.span_start)
                    report_mismatch("span_start", int'(got.span_start),
                                    int'(want.span_start));
                if (got.span_end != want.span_end)
                    report_mismatch("span_end", int'(got.span_end), int'(want.span_end));
                if (got.last != want.last)
                    report_mismatch("last", int'(got.last), int'(want.last));
            end
        end
    end

    always @(posedge clk)
    begin
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Timeout after %0d quiet cycles", quiet_cycles);
            $display("circle_span_rasterizer: mismatch");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        circle_if.valid = 1'b0;
        circle_if.payload = '0;
        span_if.ready = 1'b0;
        offer_open = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        quiet_cycles = 0;
        circles_sent = 0;
        spans_checked = 0;
        errors = 0;
        width_copy = csr_pkg::FW_RESET;
        height_copy = csr_pkg::FH_RESET;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Extremes of size and position, rings of every thickness class, and clipping on each side.
        circle_queue.push_back(make_circle(1'b0, 5, 5, 0, 0));
        circle_queue.push_back(make_circle(1'b1, 5, 5, 0, 0));
        circle_queue.push_back(make_circle(1'b0, 100, 100, 15, 15));
        circle_queue.push_back(make_circle(1'b1, 100, 100, 15, 0));
        circle_queue.push_back(make_circle(1'b1, 200, 100, 15, 3));
        circle_queue.push_back(make_circle(1'b1, 300, 100, 7, 7));
        circle_queue.push_back(make_circle(1'b1, 300, 200, 5, 12));
        circle_queue.push_back(make_circle(1'b0, -3, -3, 10, 0));
        circle_queue.push_back(make_circle(1'b1, -3, 2, 10, 4));
        circle_queue.push_back(make_circle(1'b0, 1020, 478, 9, 0));
        circle_queue.push_back(make_circle(1'b1, 1022, 470, 12, 2));
        circle_queue.push_back(make_circle(1'b0, -2048, -2048, 15, 0));
        circle_queue.push_back(make_circle(1'b1, 2047, 2047, 15, 15));
        circle_queue.push_back(make_circle(1'b0, -100, 100, 15, 0));
        circle_queue.push_back(make_circle(1'b1, 2047, 10, 15, 1));
        circle_queue.push_back(make_circle(1'b0, 40, -2048, 15, 0));
        circle_queue.push_back(make_circle(1'b0, -2048, 40, 15, 5));
        circle_queue.push_back(make_circle(1'b1, 15, 15, 15, 14));
        circle_queue.push_back(make_circle(1'b0, 1023, 479, 1, 0));
        circle_queue.push_back(make_circle(1'b1, 0, 0, 1, 1));
        drain();

        run_phase(0, 0, 40);
        write_reg(csr_pkg::CFG_FRAME_WIDTH, 1280);
        write_reg(csr_pkg::CFG_FRAME_HEIGHT, 720);
        run_phase(45, 0, 50);
        write_reg(csr_pkg::CFG_FRAME_WIDTH, 1);
        write_reg(csr_pkg::CFG_FRAME_HEIGHT, 1);
        run_phase(0, 45, 40);
        write_reg(csr_pkg::CFG_FRAME_WIDTH, 0);
        write_reg(csr_pkg::CFG_FRAME_HEIGHT, 0);
        run_phase(0, 0, 6);
        write_reg(csr_pkg::CFG_FRAME_WIDTH, 2047);
        write_reg(csr_pkg::CFG_FRAME_HEIGHT, 1023);
        run_phase(6, 6, 50);
        write_reg(csr_pkg::CFG_FRAME_WIDTH, 40);
        write_reg(csr_pkg::CFG_FRAME_HEIGHT, 30);
        run_phase(0, 45, 50);

        if (span_expect.size() != 0)
            report_mismatch("spans still expected at end", 0, span_expect.size());
        $display("Checked %0d spans from %0d circles over six frame settings,", spans_checked,
                 circles_sent);
        $display("including zero-size and oversized frames, with and without idling.");
        if (errors == 0)
            $display("circle_span_rasterizer: match");
        else
            $display("circle_span_rasterizer: mismatch");
        $finish;
    end
endmodule
